// ===== rtl/bc13_pkg.sv =====
package bc13_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // reset values of the configuration registers
    localparam logic        FORMAT_MODE_RST  = 1'b0;
    localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd4;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd4;

    // constant division by reciprocal multiply, one correction step
    localparam int unsigned RECIP_SHIFT = 16;
    localparam logic [15:0] DIV3_M  = 16'((1 << RECIP_SHIFT) / 3);
    localparam logic [15:0] DIV5_M  = 16'((1 << RECIP_SHIFT) / 5);
    localparam logic [15:0] DIV7_M  = 16'((1 << RECIP_SHIFT) / 7);
    localparam logic [15:0] DIV31_M = 16'((1 << RECIP_SHIFT) / 31);
    localparam logic [15:0] DIV63_M = 16'((1 << RECIP_SHIFT) / 63);
    localparam logic [5:0]  DIV3_D  = 6'd3;
    localparam logic [5:0]  DIV5_D  = 6'd5;
    localparam logic [5:0]  DIV7_D  = 6'd7;
    localparam logic [5:0]  DIV31_D = 6'd31;
    localparam logic [5:0]  DIV63_D = 6'd63;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // colour word and alpha word as registered at the decoder input
    typedef struct packed {
        logic [63:0] color_word;
        logic [63:0] alpha_word;
        logic        dxt5;
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [15:0] mask;
    } blk_in_t;

    // endpoints after expansion to 8 bits
    typedef struct packed {
        logic [1:0][7:0] red_end;
        logic [1:0][7:0] green_end;
        logic [1:0][7:0] blue_end;
        logic            four_colour;
        logic [31:0]     color_idx;
        logic [7:0]      a0;
        logic [7:0]      a1;
        logic [47:0]     alpha_idx;
        logic            dxt5;
        logic [15:0]     base_x;
        logic [15:0]     base_y;
        logic [15:0]     mask;
    } blk_end_t;

    // full palettes, ready for the pixel emitter
    typedef struct packed {
        logic [3:0][7:0] pal_red;
        logic [3:0][7:0] pal_green;
        logic [3:0][7:0] pal_blue;
        logic [3:0][7:0] pal_alpha;
        logic [7:0][7:0] alpha_pal;
        logic [31:0]     color_idx;
        logic [47:0]     alpha_idx;
        logic            dxt5;
        logic [15:0]     base_x;
        logic [15:0]     base_y;
        logic [15:0]     mask;
    } blk_pal_t;

    function automatic logic [13:0] divq(input logic [13:0] p, input logic [15:0] m,
                                         input logic [5:0] d);
        logic [29:0] prod;
        logic [13:0] q0;
        logic [13:0] rem;
        prod = 30'(p) * 30'(m);
        q0   = prod[29:16];
        rem  = p - 14'(q0 * 14'(d));
        if (rem >= 14'(d)) begin
            q0 = q0 + 14'd1;
        end
        return q0;
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [13:0] q;
        q = divq(14'(v) * 14'd255, DIV31_M, DIV31_D);
        return q[7:0];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] q;
        q = divq(14'(v) * 14'd255, DIV63_M, DIV63_D);
        return q[7:0];
    endfunction

endpackage

// ===== rtl/bc1_bc3_texture_block_decoder_unit.sv =====
// BC1/BC3 (DXT1/DXT5) block decoder. Compressed 64-bit words arrive on the s_ channel in
// raster block order; in DXT5 mode each block is an alpha word followed by a colour word.
// Decoded RGBA pixels leave on the m_ channel one per cycle while m_ready allows, in
// row-major order inside the block, with pixels beyond image_width/image_height left out
// and m_last_of_block on the final pixel of each block. A fully inside block occupies the
// pixel emitter for all 16 of its pixels, which sets the sustained rate; a DXT5 alpha word
// and a fully clipped block never reach the emitter. The next block is decoded in a
// three-stage pipeline (input, endpoint expansion, palettes) while the current one is
// emitted, so a new word is taken every cycle whenever the emitter has room. The user must
// write configuration over the APB port only while the block is idle; the block does not
// enforce this. Writing format_mode drops any stored alpha word.
module bc1_bc3_texture_block_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_x,
    output logic [15:0] m_pixel_y,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic        m_last_of_block
);

    logic        format_mode_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        awaiting_reg;
    logic        awaiting_next;
    logic [63:0] saved_alpha_reg;
    logic [13:0] block_column_reg;
    logic [13:0] block_column_next;
    logic [13:0] block_row_reg;
    logic [13:0] block_row_next;

    logic        cfg_write;
    logic [1:0]  cfg_idx;
    logic        alpha_step;
    logic        word_accept;
    logic        color_accept;

    bc13_pkg::blk_in_t  dec_in;
    logic               dec_in_valid;
    logic               dec_in_ready;
    bc13_pkg::blk_pal_t dec_out;
    logic               dec_out_valid;
    logic               dec_out_ready;

    logic               emit_valid_reg;
    logic               emit_valid_next;
    bc13_pkg::blk_pal_t emit_blk_reg;
    logic [15:0]        emit_rem_reg;
    logic [15:0]        emit_rem_next;
    logic [15:0]        rem_after;
    logic [3:0]         pix;
    logic               pix_last;
    logic               out_free;
    logic               emit_fire;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [1:0]         ci;
    logic [2:0]         ai;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            bc13_pkg::REG_FORMAT_MODE:  prdata = {31'd0, format_mode_reg};
            bc13_pkg::REG_IMAGE_WIDTH:  prdata = {16'd0, image_width_reg};
            bc13_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // input request handling
    assign s_ready      = dec_in_ready;
    assign word_accept  = s_valid && s_ready;
    assign alpha_step   = format_mode_reg && !awaiting_reg;
    assign color_accept = word_accept && !alpha_step;

    // clip mask and block position
    always_comb begin
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [3:0]  col_ok;
        logic [3:0]  row_ok;
        logic [14:0] blocks_x;
        logic [14:0] blocks_y;
        logic [13:0] col_inc;
        logic [13:0] row_inc;
        base_x = {block_column_reg, 2'b00};
        base_y = {block_row_reg, 2'b00};
        for (int c = 0; c < 4; c++) begin
            col_ok[c] = (base_x + 16'(c)) < image_width_reg;
            row_ok[c] = (base_y + 16'(c)) < image_height_reg;
        end
        dec_in.color_word = s_block_word;
        dec_in.alpha_word = saved_alpha_reg;
        dec_in.dxt5       = format_mode_reg;
        dec_in.base_x     = base_x;
        dec_in.base_y     = base_y;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                dec_in.mask[4 * r + c] = row_ok[r] && col_ok[c];
            end
        end

        blocks_x = 15'((17'(image_width_reg) + 17'd3) >> 2);
        blocks_y = 15'((17'(image_height_reg) + 17'd3) >> 2);
        col_inc  = block_column_reg + 14'd1;
        row_inc  = block_row_reg + 14'd1;
        block_column_next = block_column_reg;
        block_row_next    = block_row_reg;
        if (color_accept) begin
            block_column_next = col_inc;
            if ({1'b0, col_inc} >= blocks_x) begin
                block_column_next = 14'd0;
                block_row_next    = ({1'b0, row_inc} >= blocks_y) ? 14'd0 : row_inc;
            end
        end

        awaiting_next = awaiting_reg;
        if (cfg_write && cfg_idx == bc13_pkg::REG_FORMAT_MODE) begin
            awaiting_next = 1'b0;
        end else if (word_accept) begin
            awaiting_next = alpha_step;
        end
    end

    // fully clipped blocks never enter the decoder
    assign dec_in_valid = s_valid && !alpha_step && (dec_in.mask != 16'd0);

    bc13_decode_pipe u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_in_valid),
        .in_ready  (dec_in_ready),
        .in_blk    (dec_in),
        .out_valid (dec_out_valid),
        .out_ready (dec_out_ready),
        .out_blk   (dec_out)
    );

    // pixel emitter: walks the remaining inside pixels lowest first
    always_comb begin
        pix = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (emit_rem_reg[i]) begin
                pix = 4'(i);
            end
        end
    end

    assign rem_after     = emit_rem_reg & (emit_rem_reg - 16'd1);
    assign pix_last      = (rem_after == 16'd0);
    assign out_free      = !m_valid_reg || m_ready;
    assign emit_fire     = emit_valid_reg && out_free;
    assign dec_out_ready = !emit_valid_reg || (emit_fire && pix_last);
    assign ci            = emit_blk_reg.color_idx[2 * pix +: 2];
    assign ai            = emit_blk_reg.alpha_idx[3 * pix +: 3];

    always_comb begin
        emit_valid_next = emit_valid_reg;
        emit_rem_next   = emit_rem_reg;
        if (dec_out_ready && dec_out_valid) begin
            emit_valid_next = 1'b1;
            emit_rem_next   = dec_out.mask;
        end else if (emit_fire) begin
            emit_rem_next = rem_after;
            if (pix_last) begin
                emit_valid_next = 1'b0;
            end
        end
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg  <= bc13_pkg::FORMAT_MODE_RST;
            image_width_reg  <= bc13_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= bc13_pkg::IMAGE_HEIGHT_RST;
            awaiting_reg     <= 1'b0;
            saved_alpha_reg  <= 64'd0;
            block_column_reg <= 14'd0;
            block_row_reg    <= 14'd0;
            emit_valid_reg   <= 1'b0;
            emit_rem_reg     <= 16'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_idx)
                    bc13_pkg::REG_FORMAT_MODE:  format_mode_reg  <= pwdata[0];
                    bc13_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[15:0];
                    bc13_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (word_accept && alpha_step) begin
                saved_alpha_reg <= s_block_word;
            end
            awaiting_reg     <= awaiting_next;
            block_column_reg <= block_column_next;
            block_row_reg    <= block_row_next;
            emit_valid_reg   <= emit_valid_next;
            emit_rem_reg     <= emit_rem_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_out_ready && dec_out_valid) begin
            emit_blk_reg <= dec_out;
        end
        if (emit_fire) begin
            m_pixel_x       <= emit_blk_reg.base_x + 16'(pix[1:0]);
            m_pixel_y       <= emit_blk_reg.base_y + 16'(pix[3:2]);
            m_red           <= emit_blk_reg.pal_red[ci];
            m_green         <= emit_blk_reg.pal_green[ci];
            m_blue          <= emit_blk_reg.pal_blue[ci];
            m_alpha         <= emit_blk_reg.dxt5 ? emit_blk_reg.alpha_pal[ai]
                                                 : emit_blk_reg.pal_alpha[ci];
            m_last_of_block <= pix_last;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_emit_has_pixels: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid_reg |-> (emit_rem_reg != 16'd0))
        else $error("emitter holds a block with no pixels left");

    a_emit_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && !pix_last) |=> emit_valid_reg)
        else $error("emitter dropped a block before its last pixel");

    a_no_alpha_in_dxt1: assert property (@(posedge aclk) disable iff (!aresetn)
        !format_mode_reg |-> !awaiting_reg)
        else $error("alpha word pending while in DXT1 mode");

    a_pixel_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_pixel_x < image_width_reg && m_pixel_y < image_height_reg))
        else $error("emitted pixel lies outside the image");
`endif

endmodule

// ===== rtl/bc13_decode_pipe.sv =====
module bc13_decode_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bc13_pkg::blk_in_t in_blk,
    output logic              out_valid,
    input  logic              out_ready,
    output bc13_pkg::blk_pal_t out_blk
);

    logic               in_valid_reg;
    logic               end_valid_reg;
    logic               pal_valid_reg;
    bc13_pkg::blk_in_t  in_blk_reg;
    bc13_pkg::blk_end_t end_blk_reg;
    bc13_pkg::blk_pal_t pal_blk_reg;
    bc13_pkg::blk_end_t end_blk_next;
    bc13_pkg::blk_pal_t pal_blk_next;
    logic               pal_ready;
    logic               end_ready;

    assign pal_ready = !pal_valid_reg || out_ready;
    assign end_ready = !end_valid_reg || pal_ready;
    assign in_ready  = !in_valid_reg || end_ready;

    // endpoint expansion
    always_comb begin
        logic [15:0] c0;
        logic [15:0] c1;
        c0 = in_blk_reg.color_word[15:0];
        c1 = in_blk_reg.color_word[31:16];
        end_blk_next.red_end[0]   = bc13_pkg::expand5(c0[15:11]);
        end_blk_next.green_end[0] = bc13_pkg::expand6(c0[10:5]);
        end_blk_next.blue_end[0]  = bc13_pkg::expand5(c0[4:0]);
        end_blk_next.red_end[1]   = bc13_pkg::expand5(c1[15:11]);
        end_blk_next.green_end[1] = bc13_pkg::expand6(c1[10:5]);
        end_blk_next.blue_end[1]  = bc13_pkg::expand5(c1[4:0]);
        end_blk_next.four_colour  = in_blk_reg.dxt5 || (c0 > c1);
        end_blk_next.color_idx    = in_blk_reg.color_word[63:32];
        end_blk_next.a0           = in_blk_reg.alpha_word[7:0];
        end_blk_next.a1           = in_blk_reg.alpha_word[15:8];
        end_blk_next.alpha_idx    = in_blk_reg.alpha_word[63:16];
        end_blk_next.dxt5         = in_blk_reg.dxt5;
        end_blk_next.base_x       = in_blk_reg.base_x;
        end_blk_next.base_y       = in_blk_reg.base_y;
        end_blk_next.mask         = in_blk_reg.mask;
    end

    // colour and alpha palettes
    always_comb begin
        logic [1:0][7:0] ch [3];
        logic [13:0]     q;
        logic [13:0]     wsum;
        ch[0] = end_blk_reg.red_end;
        ch[1] = end_blk_reg.green_end;
        ch[2] = end_blk_reg.blue_end;
        pal_blk_next = '0;
        for (int k = 0; k < 3; k++) begin
            logic [3:0][7:0] pal;
            pal[0] = ch[k][0];
            pal[1] = ch[k][1];
            if (end_blk_reg.four_colour) begin
                q      = bc13_pkg::divq({5'b0, ch[k][0], 1'b0} + 14'(ch[k][1]),
                                        bc13_pkg::DIV3_M, bc13_pkg::DIV3_D);
                pal[2] = q[7:0];
                q      = bc13_pkg::divq(14'(ch[k][0]) + {5'b0, ch[k][1], 1'b0},
                                        bc13_pkg::DIV3_M, bc13_pkg::DIV3_D);
                pal[3] = q[7:0];
            end else begin
                wsum   = 14'(ch[k][0]) + 14'(ch[k][1]);
                pal[2] = wsum[8:1];
                pal[3] = 8'd0;
            end
            case (k)
                0:       pal_blk_next.pal_red   = pal;
                1:       pal_blk_next.pal_green = pal;
                default: pal_blk_next.pal_blue  = pal;
            endcase
        end
        pal_blk_next.pal_alpha[0] = bc13_pkg::CHAN_MAX;
        pal_blk_next.pal_alpha[1] = bc13_pkg::CHAN_MAX;
        pal_blk_next.pal_alpha[2] = bc13_pkg::CHAN_MAX;
        pal_blk_next.pal_alpha[3] = end_blk_reg.four_colour ? bc13_pkg::CHAN_MAX : 8'd0;

        pal_blk_next.alpha_pal[0] = end_blk_reg.a0;
        pal_blk_next.alpha_pal[1] = end_blk_reg.a1;
        if (end_blk_reg.a0 > end_blk_reg.a1) begin
            for (int i = 1; i <= 6; i++) begin
                wsum = 14'(7 - i) * 14'(end_blk_reg.a0) + 14'(i) * 14'(end_blk_reg.a1);
                q    = bc13_pkg::divq(wsum, bc13_pkg::DIV7_M, bc13_pkg::DIV7_D);
                pal_blk_next.alpha_pal[i + 1] = q[7:0];
            end
        end else begin
            for (int i = 1; i <= 4; i++) begin
                wsum = 14'(5 - i) * 14'(end_blk_reg.a0) + 14'(i) * 14'(end_blk_reg.a1);
                q    = bc13_pkg::divq(wsum, bc13_pkg::DIV5_M, bc13_pkg::DIV5_D);
                pal_blk_next.alpha_pal[i + 1] = q[7:0];
            end
            pal_blk_next.alpha_pal[6] = 8'd0;
            pal_blk_next.alpha_pal[7] = bc13_pkg::CHAN_MAX;
        end
        pal_blk_next.color_idx = end_blk_reg.color_idx;
        pal_blk_next.alpha_idx = end_blk_reg.alpha_idx;
        pal_blk_next.dxt5      = end_blk_reg.dxt5;
        pal_blk_next.base_x    = end_blk_reg.base_x;
        pal_blk_next.base_y    = end_blk_reg.base_y;
        pal_blk_next.mask      = end_blk_reg.mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            end_valid_reg <= 1'b0;
            pal_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (end_ready) begin
                end_valid_reg <= in_valid_reg;
            end
            if (pal_ready) begin
                pal_valid_reg <= end_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_blk_reg <= in_blk;
        end
        if (end_ready && in_valid_reg) begin
            end_blk_reg <= end_blk_next;
        end
        if (pal_ready && end_valid_reg) begin
            pal_blk_reg <= pal_blk_next;
        end
    end

    assign out_valid = pal_valid_reg;
    assign out_blk   = pal_blk_reg;

endmodule
